/* hdl/lptr_pkg.sv */
// Shared constants and types of the low-power timer register block.
package lptr_pkg;

    localparam int SPACE_BYTES_DEFAULT = 64;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 32;

    // Request codes
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Word indices of the timer registers (byte offset >> 2)
    localparam int W_ISR = 0;
    localparam int W_ICR = 1;
    localparam int W_CR  = 4;
    localparam int W_CMP = 5;
    localparam int W_ARR = 6;
    localparam int W_CNT = 7;

    // Status and control bit positions
    localparam int BIT_CMPOK  = 3;
    localparam int BIT_ARROK  = 4;
    localparam int BIT_ENABLE = 0;
    localparam int BIT_SNGSTRT = 1;
    localparam int BIT_CNTSTRT = 2;

    localparam logic [DATA_W-1:0] ARR_RESET = 32'd1;

    // Commands from the register decode to the counter
    typedef struct packed {
        logic tick;
        logic start;
        logic stop;
    } t_timer_cmd;

endpackage

/* hdl/low_power_timer_registers.sv */
// Top level of the low-power timer register block: decode, register file and result stage.
//
// Usage: each input item is a bus read, a bus write or one counter tick, given as
// i_req_type, i_byte_offset and i_write_data on a valid/ready channel. Every item
// gives exactly one result item, o_read_data and o_bad_offset, on a second
// valid/ready channel.
// The result is registered and valid the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken. All state (status, control,
// compare, reload, counter, shadow words) is updated at the edge that accepts the item,
// so the next item sees it at once. The rate is set by the result register, which
// together with the shadow RAM's registered read port forms the only stage.
// Stall: while a result waits and the receiver holds i_out_ready low, o_in_ready
// drops and the result (including the RAM read data, whose port is only enabled
// on acceptance) holds. It rises again in the cycle the result is taken.
// Reset: synchronous, active low. The counter stops at zero, all words read zero
// except auto-reload, which reads one; shadow words are tracked by valid bits
// cleared at once, so no clearing pass is needed.
// Read and write offsets at or beyond SPACE_BYTES read zero, ignore writes and raise o_bad_offset.
module low_power_timer_registers #(
    parameter int SPACE_BYTES = lptr_pkg::SPACE_BYTES_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_req_type,
    input  logic [lptr_pkg::ADDR_W-1:0] i_byte_offset,
    input  logic [lptr_pkg::DATA_W-1:0] i_write_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lptr_pkg::DATA_W-1:0] o_read_data,
    output logic                        o_bad_offset
);

    import lptr_pkg::*;

    localparam int WORDS  = SPACE_BYTES / 4;
    localparam int AW     = $clog2(WORDS);
    localparam int IDX_W  = ADDR_W - 2;

    // Accept logic
    logic accept;
    assign o_in_ready = !o_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Decode the item
    logic            is_read, is_write, is_tick, bad;
    logic [IDX_W-1:0] idx_full;
    logic [AW-1:0]   word;
    logic            w_isr, w_icr, w_cr, w_cmp, w_arr, w_cnt, w_shadow;

    assign is_read  = (i_req_type == REQ_READ);
    assign is_write = (i_req_type == REQ_WRITE);
    assign is_tick  = (i_req_type == REQ_TICK);
    assign bad      = (is_read || is_write) && (i_byte_offset >= ADDR_W'(SPACE_BYTES));
    assign idx_full = i_byte_offset[ADDR_W-1:2];

    // Fold the tail of a space that is not a whole number of words back to word zero
    always_comb begin
        if (idx_full >= IDX_W'(WORDS)) begin
            word = AW'(idx_full - IDX_W'(WORDS));
        end else begin
            word = AW'(idx_full);
        end
    end

    assign w_isr    = (word == AW'(W_ISR));
    assign w_icr    = (word == AW'(W_ICR));
    assign w_cr     = (word == AW'(W_CR));
    assign w_cmp    = (word == AW'(W_CMP));
    assign w_arr    = (word == AW'(W_ARR));
    assign w_cnt    = (word == AW'(W_CNT));
    assign w_shadow = !(w_isr || w_icr || w_cr || w_cmp || w_arr || w_cnt);

    logic wr_ok, rd_ok;
    assign wr_ok = accept && is_write && !bad;
    assign rd_ok = accept && is_read && !bad;

    // Dedicated timer registers
    logic [DATA_W-1:0] r_isr, n_isr;
    logic [DATA_W-1:0] r_cr, n_cr;
    logic [DATA_W-1:0] r_cmp, n_cmp;
    logic [DATA_W-1:0] r_arr, n_arr;
    logic [DATA_W-1:0] flag_mask;

    assign flag_mask = (DATA_W'(1) << BIT_CMPOK) | (DATA_W'(1) << BIT_ARROK);

    always_comb begin
        n_isr = r_isr;
        n_cr  = r_cr;
        n_cmp = r_cmp;
        n_arr = r_arr;
        if (wr_ok) begin
            if (w_isr) begin
                n_isr = i_write_data;
            end
            if (w_icr) begin
                // write one to clear the ready flags
                n_isr = r_isr & ~(i_write_data & flag_mask);
            end
            if (w_cr) begin
                n_cr = i_write_data;
            end
            if (w_cmp) begin
                n_cmp = i_write_data;
                n_isr = r_isr | (DATA_W'(1) << BIT_CMPOK);
            end
            if (w_arr) begin
                n_arr = i_write_data;
                n_isr = r_isr | (DATA_W'(1) << BIT_ARROK);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_isr <= '0;
            r_cr  <= '0;
            r_cmp <= '0;
            r_arr <= ARR_RESET;
        end else begin
            r_isr <= n_isr;
            r_cr  <= n_cr;
            r_cmp <= n_cmp;
            r_arr <= n_arr;
        end
    end

    // Counter
    t_timer_cmd        timer_cmd;
    logic [DATA_W-1:0] count;
    logic              counting;

    assign timer_cmd.tick  = accept && is_tick;
    assign timer_cmd.start = wr_ok && w_cr && i_write_data[BIT_ENABLE]
                             && (i_write_data[BIT_SNGSTRT] || i_write_data[BIT_CNTSTRT]);
    assign timer_cmd.stop  = wr_ok && w_cr && !i_write_data[BIT_ENABLE];

    lptr_timer u_timer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (timer_cmd),
        .i_arr      (r_arr),
        .o_count    (count),
        .o_counting (counting)
    );

    // Plain shadow words: RAM plus one valid bit per word
    logic              r_valid [WORDS];
    logic [DATA_W-1:0] ram_rdata;
    logic              ram_we;

    assign ram_we = wr_ok && w_shadow;

    lptr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (word),
        .i_wdata (i_write_data),
        .i_re    (rd_ok),
        .i_raddr (word),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WORDS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (ram_we) begin
            r_valid[word] <= 1'b1;
        end
    end

    // Result stage
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_rd, n_rd;
    logic              r_from_ram, n_from_ram;
    logic              r_bad, n_bad;

    always_comb begin
        n_rd       = '0;
        n_from_ram = 1'b0;
        if (rd_ok) begin
            if (w_cnt) begin
                n_rd = count;
            end else if (w_isr) begin
                n_rd = r_isr;
            end else if (w_cr) begin
                n_rd = r_cr;
            end else if (w_cmp) begin
                n_rd = r_cmp;
            end else if (w_arr) begin
                n_rd = r_arr;
            end else if (w_shadow) begin
                n_from_ram = r_valid[word];
            end
        end
        n_bad       = bad;
        n_out_valid = accept || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // hold the result payload while it waits
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd       <= n_rd;
            r_from_ram <= n_from_ram;
            r_bad      <= n_bad;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_from_ram ? ram_rdata : r_rd;
    assign o_bad_offset = r_bad;

    // Checks
    a_bad_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_bad) |-> (o_read_data == '0))
        else $error("bad offset result carries data");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (timer_cmd.tick && counting && (count >= r_arr)) |=> (count == '0))
        else $error("counter did not wrap at auto-reload");

    a_arrok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_ok && w_arr) |=> r_isr[BIT_ARROK])
        else $error("ARROK not set after auto-reload write");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result stage");

endmodule

/* hdl/lptr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module lptr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/lptr_timer.sv */
// Counter and run flag of the low-power timer.
module lptr_timer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lptr_pkg::t_timer_cmd        i_cmd,
    input  logic [lptr_pkg::DATA_W-1:0] i_arr,
    output logic [lptr_pkg::DATA_W-1:0] o_count,
    output logic                        o_counting
);

    import lptr_pkg::*;

    logic [DATA_W-1:0] r_count, n_count;
    logic              r_counting, n_counting;

    always_comb begin
        n_count    = r_count;
        n_counting = r_counting;
        if (i_cmd.tick && r_counting) begin
            // wrap once the reload value is reached or passed
            n_count = (r_count >= i_arr) ? '0 : r_count + DATA_W'(1);
        end else if (i_cmd.start) begin
            if (!r_counting) begin
                n_count = '0;
            end
            n_counting = 1'b1;
        end else if (i_cmd.stop) begin
            n_counting = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_counting <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_counting <= n_counting;
        end
    end

    assign o_count    = r_count;
    assign o_counting = r_counting;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the low-power timer register block.
module testbench;
    import lptr_pkg::*;

    localparam int SPACE_BYTES = SPACE_BYTES_DEFAULT;
    localparam int WORD_COUNT  = SPACE_BYTES / 4;

    // The spare request code: the block must answer it with an all-zero result
    localparam logic [1:0] REQ_NONE = 2'd3;

    // Byte offsets of the timer registers
    localparam logic [15:0] OFF_ISR   = 16'(W_ISR * 4);
    localparam logic [15:0] OFF_ICR   = 16'(W_ICR * 4);
    localparam logic [15:0] OFF_CR    = 16'(W_CR * 4);
    localparam logic [15:0] OFF_CMP   = 16'(W_CMP * 4);
    localparam logic [15:0] OFF_ARR   = 16'(W_ARR * 4);
    localparam logic [15:0] OFF_CNT   = 16'(W_CNT * 4);
    localparam logic [15:0] OFF_SPACE = 16'(SPACE_BYTES);

    // Control word values used by the directed rows
    localparam logic [31:0] CR_STOP      = 32'd0;
    localparam logic [31:0] CR_RUN_CONT  = 32'(1 << BIT_ENABLE) | 32'(1 << BIT_CNTSTRT);
    localparam logic [31:0] CR_RUN_SINGL = 32'(1 << BIT_ENABLE) | 32'(1 << BIT_SNGSTRT);

    // Allow for the slowest legal run many times over
    localparam int TIMEOUT_NS = 4_000_000;

    typedef struct packed {
        logic [31:0] data;
        logic        bad;
    } t_read_result;

    // One row of the directed table; typed rows carry their own expected result
    typedef struct packed {
        logic [1:0]   req;
        logic [15:0]  off;
        logic [31:0]  data;
        logic         typed;
        t_read_result want;
    } t_stim_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [1:0]  i_req_type    = REQ_READ;
    logic [15:0] i_byte_offset = '0;
    logic [31:0] i_write_data  = '0;
    logic        i_out_ready   = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_read_data;
    logic        o_bad_offset;

    // Own copy of the timer state, advanced once per accepted item
    logic [31:0] model_words [WORD_COUNT];
    logic        model_running;
    logic [31:0] model_count;

    t_read_result expected_reads [$];
    int           mismatch_count = 0;
    int           items_done     = 0;
    int           send_gap_pct   = 0;
    int           recv_stall_pct = 0;

    // Directed rows: reset values, range edges, every request code, the flag
    // handshake, a lowered reload, a restart while running and a freeze.
    t_stim_row directed_rows [25] = '{
        '{REQ_READ,  OFF_ARR,       32'd0,         1'b1, '{32'd1, 1'b0}},
        '{REQ_TICK,  OFF_ISR,       32'd0,         1'b1, '{32'd0, 1'b0}},
        '{REQ_READ,  16'hFFFF,      32'd0,         1'b1, '{32'd0, 1'b1}},
        '{REQ_WRITE, OFF_SPACE,     32'hFFFF_FFFF, 1'b1, '{32'd0, 1'b1}},
        '{REQ_NONE,  16'hFFFF,      32'hFFFF_FFFF, 1'b1, '{32'd0, 1'b0}},
        '{REQ_WRITE, OFF_ARR,       32'd2,         1'b1, '{32'd0, 1'b0}},
        '{REQ_WRITE, OFF_CMP,       32'hFFFF_FFFF, 1'b1, '{32'd0, 1'b0}},
        '{REQ_READ,  OFF_ISR,       32'd0,         1'b0, '{32'd0, 1'b0}},
        '{REQ_WRITE, OFF_CR,        CR_RUN_CONT,   1'b1, '{32'd0, 1'b0}},
        '{REQ_TICK,  OFF_ISR,       32'd0,         1'b1, '{32'd0, 1'b0}},
        '{REQ_TICK,  OFF_ISR,       32'd0,         1'b1, '{32'd0, 1'b0}},
        '{REQ_TICK,  OFF_ISR,       32'd0,         1'b1, '{32'd0, 1'b0}},
        '{REQ_TICK,  OFF_ISR,       32'd0,         1'b1, '{32'd0, 1'b0}},
        '{REQ_TICK,  OFF_ISR,       32'd0,         1'b1, '{32'd0, 1'b0}},
        '{REQ_WRITE, OFF_ARR,       32'd1,         1'b1, '{32'd0, 1'b0}},
        '{REQ_TICK,  OFF_ISR,       32'd0,         1'b1, '{32'd0, 1'b0}},
        '{REQ_TICK,  OFF_ISR,       32'd0,         1'b1, '{32'd0, 1'b0}},
        '{REQ_WRITE, OFF_CR,        CR_RUN_SINGL,  1'b1, '{32'd0, 1'b0}},
        '{REQ_READ,  OFF_CNT | 16'd3, 32'd0,       1'b0, '{32'd0, 1'b0}},
        '{REQ_WRITE, OFF_CR,        CR_STOP,       1'b1, '{32'd0, 1'b0}},
        '{REQ_TICK,  OFF_ISR,       32'd0,         1'b1, '{32'd0, 1'b0}},
        '{REQ_WRITE, OFF_CNT,       32'hDEAD_BEEF, 1'b1, '{32'd0, 1'b0}},
        '{REQ_READ,  OFF_CNT,       32'd0,         1'b0, '{32'd0, 1'b0}},
        '{REQ_WRITE, OFF_ICR,       32'hFFFF_FFFF, 1'b1, '{32'd0, 1'b0}},
        '{REQ_READ,  OFF_ISR,       32'd0,         1'b0, '{32'd0, 1'b0}}
    };

    low_power_timer_registers #(
        .SPACE_BYTES(SPACE_BYTES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_byte_offset (i_byte_offset),
        .i_write_data  (i_write_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_data   (o_read_data),
        .o_bad_offset  (o_bad_offset)
    );

    always #5 i_clk = ~i_clk;

    // Apply one item to the timer state and return the result it should give.
    // Writes update the status flags, ICR clears them and CR starts or freezes
    // the counter; a tick wraps to zero once the count reaches the reload word.
    function automatic t_read_result timer_step(input logic [1:0] req,
                                                input logic [15:0] off,
                                                input logic [31:0] data);
        t_read_result res;
        int unsigned  word;
        res  = '0;
        word = 32'(off[15:2]);
        if (req == REQ_READ || req == REQ_WRITE) begin
            if (off >= OFF_SPACE) begin
                res.bad = 1'b1;
            end else if (req == REQ_READ) begin
                res.data = (word == W_CNT) ? model_count : model_words[word];
            end else begin
                case (word)
                    W_ARR: begin
                        model_words[W_ARR] = data;
                        model_words[W_ISR][BIT_ARROK] = 1'b1;
                    end
                    W_CMP: begin
                        model_words[W_CMP] = data;
                        model_words[W_ISR][BIT_CMPOK] = 1'b1;
                    end
                    W_ICR: begin
                        // Write-one-to-clear; the clear word itself is never kept
                        if (data[BIT_ARROK]) model_words[W_ISR][BIT_ARROK] = 1'b0;
                        if (data[BIT_CMPOK]) model_words[W_ISR][BIT_CMPOK] = 1'b0;
                    end
                    W_CR: begin
                        model_words[W_CR] = data;
                        if (data[BIT_ENABLE] && (data[BIT_SNGSTRT] || data[BIT_CNTSTRT])) begin
                            // A restart while running keeps the count
                            if (!model_running) model_count = '0;
                            model_running = 1'b1;
                        end else if (!data[BIT_ENABLE]) begin
                            model_running = 1'b0;
                        end
                    end
                    default: model_words[word] = data;
                endcase
            end
        end else if (req == REQ_TICK && model_running) begin
            if (model_count >= model_words[W_ARR]) model_count = '0;
            else model_count = model_count + 32'd1;
        end
        return res;
    endfunction

    // Present one item from a falling edge, hold it until it is taken, then
    // record what it should give. Returns at the next falling edge with valid
    // still high, so back-to-back items never drop valid in between.
    task automatic send_item(input logic [1:0] req, input logic [15:0] off,
                             input logic [31:0] data, input logic typed,
                             input t_read_result typed_want);
        t_read_result res;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_req_type    = req;
        i_byte_offset = off;
        i_write_data  = data;
        i_in_valid    = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res = timer_step(req, off, data);
        expected_reads.push_back(typed ? typed_want : res);
        items_done++;
        @(negedge i_clk);
    endtask

    // Timer registers or any offset inside the space, now and then any offset at all
    function automatic logic [15:0] pick_offset();
        logic [15:0] off;
        int          r;
        r = $urandom_range(99);
        if (r < 10) begin
            off = 16'($urandom);
        end else if (r < 55) begin
            case ($urandom_range(5))
                0: off = OFF_ISR;
                1: off = OFF_ICR;
                2: off = OFF_CR;
                3: off = OFF_CMP;
                4: off = OFF_ARR;
                default: off = OFF_CNT;
            endcase
            off[1:0] = 2'($urandom);
        end else begin
            off = 16'($urandom_range(SPACE_BYTES - 1));
        end
        return off;
    endfunction

    // Small reload values so the counter wraps often; the odd extreme too
    function automatic logic [31:0] pick_reload();
        int r;
        r = $urandom_range(99);
        if (r < 5) return 32'hFFFF_FFFF;
        if (r < 10) return $urandom;
        return 32'($urandom_range(15));
    endfunction

    function automatic logic [31:0] pick_start_word();
        logic [31:0] d;
        d = $urandom;
        d[BIT_ENABLE] = 1'b1;
        if (!d[BIT_SNGSTRT] && !d[BIT_CNTSTRT]) d[BIT_CNTSTRT] = 1'b1;
        return d;
    endfunction

    // A well-formed run of the timer: set the reload, start, tick with reads
    // of the count in between, poke the flags, and stop at the end about half the time.
    task automatic run_timer_episode();
        logic [31:0] d;
        int          steps;
        int          r;
        steps = $urandom_range(1, 30);
        send_item(REQ_WRITE, OFF_ARR | 16'($urandom_range(3)), pick_reload(), 1'b0, '0);
        if ($urandom_range(3) == 0) send_item(REQ_WRITE, OFF_CMP, $urandom, 1'b0, '0);
        send_item(REQ_WRITE, OFF_CR, pick_start_word(), 1'b0, '0);
        repeat (steps) begin
            r = $urandom_range(99);
            if (r < 60) begin
                send_item(REQ_TICK, 16'($urandom), $urandom, 1'b0, '0);
            end else if (r < 80) begin
                send_item(REQ_READ, OFF_CNT | 16'($urandom_range(3)), $urandom, 1'b0, '0);
            end else if (r < 86) begin
                send_item(REQ_WRITE, OFF_ARR, pick_reload(), 1'b0, '0);
            end else if (r < 90) begin
                send_item(REQ_WRITE, OFF_ICR, $urandom, 1'b0, '0);
            end else if (r < 95) begin
                send_item(REQ_READ, OFF_ISR, $urandom, 1'b0, '0);
            end else begin
                // Any control word: restart, enable only, or freeze
                send_item(REQ_WRITE, OFF_CR, $urandom, 1'b0, '0);
            end
        end
        if ($urandom_range(1) == 0) begin
            d = $urandom;
            d[BIT_ENABLE] = 1'b0;
            send_item(REQ_WRITE, OFF_CR, d, 1'b0, '0);
        end
    endtask

    // Drive random traffic until the given number of items is reached
    task automatic run_random(input int stop_at);
        while (items_done < stop_at) begin
            if ($urandom_range(99) < 70) begin
                run_timer_episode();
            end else begin
                send_item(2'($urandom_range(3)), pick_offset(), $urandom, 1'b0, '0);
            end
        end
    endtask

    // Hold the sender off until every outstanding result has come back
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (expected_reads.size() != 0) @(negedge i_clk);
    endtask

    // Receiver: stall at random, redrawn every cycle
    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result taken with the oldest outstanding expectation
    always @(posedge i_clk) begin
        t_read_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_reads.size() == 0) begin
                $display("%0t: unexpected result read_data=%h bad_offset=%b",
                         $time, o_read_data, o_bad_offset);
                mismatch_count++;
            end else begin
                want = expected_reads.pop_front();
                if (o_read_data !== want.data) begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, want.data, o_read_data);
                    mismatch_count++;
                end
                if (o_bad_offset !== want.bad) begin
                    $display("%0t: bad_offset expected %b actual %b",
                             $time, want.bad, o_bad_offset);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        // Reset state of the prediction: all words zero, reload one, stopped
        foreach (model_words[i]) model_words[i] = '0;
        model_words[W_ARR] = 32'd1;
        model_running = 1'b0;
        model_count   = '0;

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table under the heaviest receiver stall
        send_gap_pct   = 29;
        recv_stall_pct = 82;
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].req, directed_rows[i].off, directed_rows[i].data,
                      directed_rows[i].typed, directed_rows[i].want);
        end

        run_random(625);
        drain_results();

        // Swap the idling sides
        send_gap_pct   = 82;
        recv_stall_pct = 29;
        run_random(1225);
        drain_results();

        // Full rate on both sides
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        run_random(1825);
        drain_results();

        // Let any stray result show up before deciding
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS low_power_timer_registers");
        end else begin
            $display("FAIL low_power_timer_registers");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL low_power_timer_registers");
        $finish;
    end

endmodule
